[rtl/max_priority_work_scheduler_assert.svh]
`ifndef MAX_PRIORITY_WORK_SCHEDULER_ASSERT_SVH
`define MAX_PRIORITY_WORK_SCHEDULER_ASSERT_SVH

// same-cycle check
`define MPWS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// next-cycle check
`define MPWS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mpws_pkg.sv]
package mpws_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PRIO_W   = 16;
  localparam int UNITS_W  = 16;
  localparam int PROD_W   = PRIO_W + UNITS_W;
  localparam int PEN_W    = 48;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_DEC,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic               valid;
    logic [PRIO_W-1:0]  prio;
    logic [UNITS_W-1:0] units;
    logic [SLOT_W-1:0]  slot;
  } cell_t;

  typedef struct packed {
    op_t   op;
    cell_t job;
  } ctrl_t;

  typedef struct packed {
    logic              alloc;
    logic [SLOT_W-1:0] alloc_slot;
    logic              release_en;
    logic [SLOT_W-1:0] release_slot;
    logic              clear;
  } slot_ctrl_t;

  // a goes ahead of b: higher priority, then lower slot
  function automatic logic beats(cell_t a, cell_t b);
    beats = a.valid && (!b.valid || (a.prio > b.prio) ||
            ((a.prio == b.prio) && (a.slot < b.slot)));
  endfunction

endpackage

[rtl/mpws_cell.sv]
module mpws_cell (
  input  logic            clk,
  input  logic            rst,
  input  mpws_pkg::ctrl_t ctrl,
  input  mpws_pkg::cell_t left,
  input  logic            left_beat,
  input  mpws_pkg::cell_t right,
  output mpws_pkg::cell_t cur,
  output logic            beat
);

  assign beat = mpws_pkg::beats(ctrl.job, cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      case (ctrl.op)
        mpws_pkg::OP_INSERT: begin
          if (beat) begin
            if (left_beat) begin
              cur <= left;
            end else begin
              cur <= ctrl.job;
            end
          end
        end
        mpws_pkg::OP_POP: begin
          cur <= right;
        end
        mpws_pkg::OP_DEC: begin
          cur.units <= cur.units - 1'b1;
        end
        mpws_pkg::OP_CLEAR: begin
          cur.valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/mpws_slot_alloc.sv]
module mpws_slot_alloc (
  input  logic                          clk,
  input  logic                          rst,
  input  mpws_pkg::slot_ctrl_t          sctrl,
  output logic [mpws_pkg::SLOT_W-1:0]   free_slot,
  output logic                          full
);

  logic [mpws_pkg::CAPACITY-1:0] used;
  logic [mpws_pkg::CAPACITY-1:0] free_bits;
  logic [mpws_pkg::CAPACITY-1:0] lowest;

  assign free_bits = ~used;
  assign lowest    = free_bits & (~free_bits + 1'b1);
  assign full      = (free_bits == '0);

  always_comb begin
    free_slot = '0;
    for (int b = 0; b < mpws_pkg::SLOT_W; b++) begin
      for (int i = 0; i < mpws_pkg::CAPACITY; i++) begin
        if (i[b]) begin
          free_slot[b] = free_slot[b] | lowest[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (sctrl.clear) begin
      used <= '0;
    end else begin
      if (sctrl.alloc) begin
        used[sctrl.alloc_slot] <= 1'b1;
      end
      if (sctrl.release_en) begin
        used[sctrl.release_slot] <= 1'b0;
      end
    end
  end

endmodule

[rtl/max_priority_work_scheduler.sv]
// Priority work scheduler. Each command word is taken when start is high and busy
// is low; busy then stays high for one cycle and the result appears in the next
// cycle with done high for exactly one cycle, and a new command may be started in
// the cycle that done is shown. The receiver cannot stall: sample the result
// fields whenever done is high. Jobs live in a sorted chain of cells, best job at
// the head, and every command updates the whole chain in one step; the command
// inputs and the registered multiply of priority times units are captured at
// acceptance ahead of the penalty accumulator. penalty is valid from the done
// cycle until the next command completes.
module max_priority_work_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd,
  input  logic [mpws_pkg::PRIO_W-1:0]    priority_req,
  input  logic [mpws_pkg::UNITS_W-1:0]   units,
  output logic                           done,
  output logic [mpws_pkg::PEN_W-1:0]     penalty,
  output logic                           served,
  output logic [mpws_pkg::PRIO_W-1:0]    served_priority,
  output logic                           dropped
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  localparam int CAP = mpws_pkg::CAPACITY;

  state_t                         state;
  logic [1:0]                     cmd_r;
  logic [mpws_pkg::PRIO_W-1:0]    prio_r;
  logic [mpws_pkg::UNITS_W-1:0]   units_r;
  logic [mpws_pkg::PROD_W-1:0]    prod_r;
  logic [mpws_pkg::SLOT_W-1:0]    slot_r;
  logic                           full_r;
  logic [mpws_pkg::PEN_W-1:0]     penalty_total;
  logic [mpws_pkg::PEN_W-1:0]     penalty_total_next;

  logic [mpws_pkg::SLOT_W-1:0]    free_slot;
  logic                           full;
  mpws_pkg::slot_ctrl_t           sctrl;
  mpws_pkg::ctrl_t                ctrl;
  mpws_pkg::ctrl_t                cell_ctrl [CAP];
  mpws_pkg::cell_t                cells [CAP];
  logic                           beat [CAP];
  logic                           served_next;
  logic [mpws_pkg::PRIO_W-1:0]    served_prio_next;
  logic                           dropped_next;
  logic [mpws_pkg::PEN_W:0]       pen_sum;

  assign busy    = (state == ST_EXEC);
  assign penalty = penalty_total;
  assign pen_sum = {1'b0, penalty_total} +
                   {{(mpws_pkg::PEN_W + 1 - mpws_pkg::PROD_W){1'b0}}, prod_r};

  always_comb begin
    ctrl.op            = mpws_pkg::OP_HOLD;
    ctrl.job.valid     = 1'b1;
    ctrl.job.prio      = prio_r;
    ctrl.job.units     = units_r;
    ctrl.job.slot      = slot_r;
    sctrl.alloc        = 1'b0;
    sctrl.alloc_slot   = slot_r;
    sctrl.release_en   = 1'b0;
    sctrl.release_slot = cells[0].slot;
    sctrl.clear        = 1'b0;
    served_next        = 1'b0;
    served_prio_next   = '0;
    dropped_next       = 1'b0;
    penalty_total_next = penalty_total;
    if (busy) begin
      case (cmd_r)
        mpws_pkg::CMD_ADD: begin
          if (units_r != '0) begin
            if (full_r) begin
              dropped_next = 1'b1;
            end else begin
              ctrl.op     = mpws_pkg::OP_INSERT;
              sctrl.alloc = 1'b1;
              if (pen_sum[mpws_pkg::PEN_W]) begin
                penalty_total_next = '1;
              end else begin
                penalty_total_next = pen_sum[mpws_pkg::PEN_W-1:0];
              end
            end
          end
        end
        mpws_pkg::CMD_TICK: begin
          if (cells[0].valid) begin
            served_next      = 1'b1;
            served_prio_next = cells[0].prio;
            if ({{(mpws_pkg::PEN_W - mpws_pkg::PRIO_W){1'b0}}, cells[0].prio}
                > penalty_total) begin
              penalty_total_next = '0;
            end else begin
              penalty_total_next = penalty_total -
                {{(mpws_pkg::PEN_W - mpws_pkg::PRIO_W){1'b0}}, cells[0].prio};
            end
            if (cells[0].units > {{(mpws_pkg::UNITS_W - 1){1'b0}}, 1'b1}) begin
              ctrl.op = mpws_pkg::OP_DEC;
            end else begin
              ctrl.op          = mpws_pkg::OP_POP;
              sctrl.release_en = 1'b1;
            end
          end
        end
        mpws_pkg::CMD_CLEAR: begin
          ctrl.op            = mpws_pkg::OP_CLEAR;
          sctrl.clear        = 1'b1;
          penalty_total_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  mpws_slot_alloc u_slots (
    .clk       (clk),
    .rst       (rst),
    .sctrl     (sctrl),
    .free_slot (free_slot),
    .full      (full)
  );

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    mpws_pkg::cell_t left_c;
    mpws_pkg::cell_t right_c;
    logic            left_b;

    if (i == 0) begin : g_head
      assign left_c = '0;
      assign left_b = 1'b0;
      assign cell_ctrl[i] = ctrl;
    end else begin : g_body
      assign left_c = cells[i-1];
      assign left_b = beat[i-1];
      always_comb begin
        cell_ctrl[i] = ctrl;
        if (ctrl.op == mpws_pkg::OP_DEC) begin
          cell_ctrl[i].op = mpws_pkg::OP_HOLD;
        end
      end
    end

    if (i == CAP - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_mid
      assign right_c = cells[i+1];
    end

    mpws_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl[i]),
      .left      (left_c),
      .left_beat (left_b),
      .right     (right_c),
      .cur       (cells[i]),
      .beat      (beat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      penalty_total <= '0;
    end else begin
      done          <= 1'b0;
      penalty_total <= penalty_total_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      cmd_r   <= cmd;
      prio_r  <= priority_req;
      units_r <= units;
      prod_r  <= priority_req * units;
      slot_r  <= free_slot;
      full_r  <= full;
    end
    if (busy) begin
      served          <= served_next;
      served_priority <= served_prio_next;
      dropped         <= dropped_next;
    end
  end

`include "max_priority_work_scheduler_assert.svh"

`MPWS_CHECK_NEXT(a_start_busy, start && !busy, busy, "accepted command did not go busy")
`MPWS_CHECK_NEXT(a_busy_done, busy, done && !busy, "result not issued after execute")
`MPWS_CHECK(a_compact, !cells[0].valid |-> !cells[1].valid, "job chain has a gap at head")
`MPWS_CHECK(a_drop_full, done && dropped |-> full, "add dropped while a slot was free")

endmodule
